// ===== design/mpe_pkg.sv =====
`default_nettype none
package mpe_pkg;

	localparam int PIX_W   = 12;
	localparam int CNT_W   = 16;
	localparam int COLOR_W = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

	localparam logic signed [31:0] RST_ORIGIN_RE = -32'sd536870912;
	localparam logic signed [31:0] RST_ORIGIN_IM = -32'sd268435456;
	localparam logic signed [31:0] RST_STEP_RE   = 32'sd1048576;
	localparam logic signed [31:0] RST_STEP_IM   = 32'sd699050;
	localparam logic [CNT_W-1:0]   RST_MAX_ITER  = 16'd1000;

	localparam logic [CNT_W-1:0] BLACK_FROM = 16'd100;
	localparam logic [3:0]       RED_SAT    = 4'd10;
	localparam logic [6:0]       BLUE_SAT   = 7'd20;
	localparam logic [COLOR_W-1:0] FULL     = 8'd255;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [CNT_W-1:0]   iterations;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} result_t;

	typedef struct packed {
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
	} point_t;

	typedef struct packed {
		logic signed [31:0] origin_re;
		logic signed [31:0] origin_im;
		logic signed [31:0] step_re;
		logic signed [31:0] step_im;
		logic [CNT_W-1:0]   max_iter;
	} cfg_t;

	typedef struct packed {
		logic push;
	} q_ctl_t;

endpackage
`default_nettype wire

// ===== design/mpe_front.sv =====
`default_nettype none
module mpe_front import mpe_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  pixel_t in_data,
	output q_ctl_t qctl,
	input  logic   q_full,
	output point_t q_data
);

	localparam int PRW  = PIX_W + 33;
	localparam int SUMW = PRW + 1;
	localparam logic [PIX_W-1:0] PX_MASK =
		(COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

	logic                  valid_s1;
	logic signed [PRW-1:0] prod_re_s1;
	logic signed [PRW-1:0] prod_im_s1;
	logic [PIX_W-1:0]      px;
	logic [PIX_W-1:0]      py;
	logic signed [SUMW-1:0] sum_re;
	logic signed [SUMW-1:0] sum_im;

	function automatic logic signed [31:0] sat32(input logic signed [SUMW-1:0] v);
		logic [SUMW-32:0] hi;
		hi = v[SUMW-1:31];
		if (hi == '0 || hi == '1) begin
			return v[31:0];
		end else if (v[SUMW-1]) begin
			return {1'b1, 31'd0};
		end else begin
			return {1'b0, {31{1'b1}}};
		end
	endfunction

	assign px = in_data.pixel_x & PX_MASK;
	assign py = in_data.pixel_y & PX_MASK;
	assign in_ready = !valid_s1 || !q_full;
	assign qctl.push = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_re_s1 <= PRW'($signed({1'b0, px}) * cfg.step_re);
			prod_im_s1 <= PRW'($signed({1'b0, py}) * cfg.step_im);
		end
	end

	always_comb begin
		sum_re = SUMW'(prod_re_s1) + SUMW'(cfg.origin_re);
		sum_im = SUMW'(prod_im_s1) + SUMW'(cfg.origin_im);
		q_data.c_re = sat32(sum_re);
		q_data.c_im = sat32(sum_im);
	end

endmodule
`default_nettype wire

// ===== design/mpe_queue.sv =====
`default_nettype none
module mpe_queue import mpe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  q_ctl_t qctl,
	input  point_t wr_data,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output point_t rd_data
);

	point_t     mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (qctl.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (qctl.push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !qctl.push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/mpe_back.sv =====
`default_nettype none
module mpe_back import mpe_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [CNT_W-1:0] max_iter,
	input  logic       q_empty,
	output logic       q_pop,
	input  point_t     q_data,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data
);

	localparam int ZW = ((FRAC_BITS + 5 > 32) ? FRAC_BITS + 5 : 32) + 1;
	localparam int MW = FRAC_BITS + 2;
	localparam int PW = 2 * MW;
	localparam int SW = PW + 2;
	localparam logic [ZW-1:0] MAG_LIM = ZW'(1) << (FRAC_BITS + 1);
	localparam logic [PW:0]   ESC_LIM = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MAG  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_UPD  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     res_q;
	logic [10:0]          y_q;
	logic signed [ZW-1:0] zr_q;
	logic signed [ZW-1:0] zi_q;
	logic signed [31:0]   cr_q;
	logic signed [31:0]   ci_q;
	logic [MW-1:0]        magr_q;
	logic [MW-1:0]        magi_q;
	logic                 big_q;
	logic                 big_mul_q;
	logic                 neg_q;
	logic                 neg_mul_q;
	logic [PW-1:0]        rr_q;
	logic [PW-1:0]        ii_q;
	logic [PW-1:0]        ri_q;
	logic                 out_valid_q;
	result_t              out_data_q;

	logic [ZW-1:0]        magr;
	logic [ZW-1:0]        magi;
	logic [PW:0]          mag_sum;
	logic signed [PW:0]   diff;
	logic signed [PW:0]   sri;
	logic signed [SW-1:0] nr;
	logic signed [SW-1:0] ni;
	logic                 escape;
	logic                 out_free;
	logic [6:0]           r7;
	logic [26:0]          gprod;
	result_t              res_w;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		magr    = zr_q[ZW-1] ? ZW'(-zr_q) : ZW'(zr_q);
		magi    = zi_q[ZW-1] ? ZW'(-zi_q) : ZW'(zi_q);
		mag_sum = (PW + 1)'(rr_q) + (PW + 1)'(ii_q);
		escape  = big_mul_q || (mag_sum > ESC_LIM);
		diff    = $signed({1'b0, rr_q}) - $signed({1'b0, ii_q});
		sri     = neg_mul_q ? -$signed({1'b0, ri_q}) : $signed({1'b0, ri_q});
		nr      = SW'(diff >>> FRAC_BITS) + SW'(cr_q);
		ni      = SW'(sri >>> (FRAC_BITS - 1)) + SW'(ci_q);
	end

	always_comb begin
		r7    = res_q[6:0];
		gprod = 27'(y_q) * 27'd52429;
		res_w.iterations = res_q;
		if (res_q >= BLACK_FROM) begin
			res_w.red   = '0;
			res_w.green = '0;
			res_w.blue  = '0;
		end else begin
			res_w.red   = (r7 >= 7'(RED_SAT)) ? FULL :
				8'(r7[3:0]) * 8'd25 + 8'(r7[3:1]);
			res_w.green = gprod[25:18];
			res_w.blue  = (r7 >= BLUE_SAT) ? 8'd0 : FULL - y_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (escape || k_q == max_iter) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MAG;
					end
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				zr_q <= '0;
				zi_q <= '0;
				k_q  <= '0;
				cr_q <= q_data.c_re;
				ci_q <= q_data.c_im;
			end
			ST_MAG: begin
				magr_q <= magr[MW-1:0];
				magi_q <= magi[MW-1:0];
				big_q  <= (magr > MAG_LIM) || (magi > MAG_LIM);
				neg_q  <= zr_q[ZW-1] ^ zi_q[ZW-1];
			end
			ST_MUL: begin
				rr_q      <= magr_q * magr_q;
				ii_q      <= magi_q * magi_q;
				ri_q      <= magr_q * magi_q;
				big_mul_q <= big_q;
				neg_mul_q <= neg_q;
			end
			ST_UPD: begin
				if (escape) begin
					res_q <= k_q - CNT_W'(1);
				end else begin
					res_q <= k_q;
					k_q   <= k_q + CNT_W'(1);
					zr_q  <= nr[ZW-1:0];
					zi_q  <= ni[ZW-1:0];
				end
			end
			ST_FIN: begin
				y_q <= 11'((13'(res_q[6:0]) * 13'd51) >> 2);
			end
			ST_EMIT: begin
				if (out_free) begin
					out_data_q <= res_w;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/mandelbrot_pixel_escape_unit.sv =====
`default_nettype none
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data (pixel_t)
// out      output     out_valid / out_ready  out_data (result_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front maps a pixel to its point c with a registered multiply and queues it in a two-entry queue.
// The back runs each iteration through its magnitude, multiply and update states and takes
// the next point from the queue only after it has emitted the last result.
// Reset restores the register defaults and empties the pipeline and the queue.
// A stalled output holds the back; the front keeps filling the queue meanwhile until it is full.
module mandelbrot_pixel_escape_unit import mpe_pkg::*; #(
	parameter int FRAC_BITS  = 28,
	parameter int COORD_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pixel_t               in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output result_t              out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t   cfg_q;
	q_ctl_t qctl;
	point_t front_data;
	point_t back_data;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_re <= RST_ORIGIN_RE;
			cfg_q.origin_im <= RST_ORIGIN_IM;
			cfg_q.step_re   <= RST_STEP_RE;
			cfg_q.step_im   <= RST_STEP_IM;
			cfg_q.max_iter  <= RST_MAX_ITER;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ORIGIN_RE: cfg_q.origin_re <= cfg_data;
				CFG_ORIGIN_IM: cfg_q.origin_im <= cfg_data;
				CFG_STEP_RE:   cfg_q.step_re   <= cfg_data;
				CFG_STEP_IM:   cfg_q.step_im   <= cfg_data;
				CFG_MAX_ITER:  cfg_q.max_iter  <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mpe_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.qctl    (qctl),
		.q_full  (q_full),
		.q_data  (front_data)
	);

	mpe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qctl   (qctl),
		.wr_data(front_data),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rd_data(back_data)
	);

	mpe_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_iter (cfg_q.max_iter),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (back_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// ===== verif/tb_mandelbrot_pixel_escape_unit.sv =====
`default_nettype none
module tb_mandelbrot_pixel_escape_unit;
	import mpe_pkg::*;

	localparam int FRAC = 28;
	localparam int Q_ONE = 1 << FRAC;
	localparam logic [127:0] ESCAPE_BOUND = 128'd1 << (2 * FRAC + 2);
	localparam int STALL_LIMIT = 800000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pixel_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	result_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic signed [31:0] vp_origin_re = RST_ORIGIN_RE;
	logic signed [31:0] vp_origin_im = RST_ORIGIN_IM;
	logic signed [31:0] vp_step_re = RST_STEP_RE;
	logic signed [31:0] vp_step_im = RST_STEP_IM;
	logic [CNT_W-1:0] vp_max_iter = RST_MAX_ITER;

	result_t due_escapes[$];
	int mismatches = 0;
	int stall_cycles = 0;
	int rx_hold_cycles = 0;
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;

	mandelbrot_pixel_escape_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic signed [63:0] plane_coord(logic signed [31:0] origin,
			logic signed [31:0] step, logic [PIX_W-1:0] idx);
		logic signed [63:0] acc;
		acc = step;
		acc = acc * $signed({1'b0, idx});
		acc = acc + origin;
		if (acc > 64'sd2147483647) begin
			acc = 64'sd2147483647;
		end else if (acc < -64'sd2147483648) begin
			acc = -64'sd2147483648;
		end
		return acc;
	endfunction

	function automatic result_t escape_time(pixel_t px);
		logic signed [63:0] c_re, c_im, zr, zi, nr, ni;
		logic signed [127:0] acc;
		logic [127:0] mag;
		int unsigned n, r, g, b;
		result_t res;
		c_re = plane_coord(vp_origin_re, vp_step_re, px.pixel_x);
		c_im = plane_coord(vp_origin_im, vp_step_im, px.pixel_y);
		zr = '0;
		zi = '0;
		n = 0;
		while (n < vp_max_iter) begin
			acc = zr * zr - zi * zi;
			acc = acc >>> FRAC;
			nr = acc[63:0] + c_re;
			acc = zr * zi;
			acc = (acc + acc) >>> FRAC;
			ni = acc[63:0] + c_im;
			zr = nr;
			zi = ni;
			acc = zr * zr;
			mag = acc;
			acc = zi * zi;
			mag = mag + acc;
			if (mag > ESCAPE_BOUND) break;
			n++;
		end
		res.iterations = n[CNT_W-1:0];
		if (n < 100) begin
			r = 255 * n / 10;
			g = 255 * n / 100;
			b = 255 * n / 20;
			if (r > 255) r = 255;
			if (b > 255) b = 255;
			res.red = r[7:0];
			res.green = g[7:0];
			res.blue = 8'(255 - b);
		end else begin
			res.red = '0;
			res.green = '0;
			res.blue = '0;
		end
		return res;
	endfunction

	task automatic compare_shade(string tag, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, tag, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_escape
		result_t want;
		if (out_valid && out_ready) begin
			if (due_escapes.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0d/%0d/%0d/%0d", $time,
					out_data.iterations, out_data.red, out_data.green, out_data.blue);
				mismatches++;
			end else begin
				want = due_escapes.pop_front();
				compare_shade("iterations", want.iterations, out_data.iterations);
				compare_shade("red", 16'(want.red), 16'(out_data.red));
				compare_shade("green", 16'(want.green), 16'(out_data.green));
				compare_shade("blue", 16'(want.blue), 16'(out_data.blue));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : result_sink
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready = 1'b0;
				repeat (rx_hold_cycles) @(negedge clk);
				rx_hold_cycles = 0;
			end
			gap = rx_gaps_on ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
		int unsigned gap;
		gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data.pixel_x = x;
		in_data.pixel_y = y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		due_escapes.insert(due_escapes.size(), escape_time(in_data));
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (due_escapes.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_ORIGIN_RE: vp_origin_re = value;
			CFG_ORIGIN_IM: vp_origin_im = value;
			CFG_STEP_RE:   vp_step_re = value;
			CFG_STEP_IM:   vp_step_im = value;
			CFG_MAX_ITER:  vp_max_iter = value[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_limit(int unsigned limit);
		logic [31:0] word;
		word = $urandom();
		word[CNT_W-1:0] = limit[CNT_W-1:0];
		write_reg(CFG_MAX_ITER, word);
	endtask

	task automatic set_window(int o_re, int o_im, int s_re, int s_im);
		write_reg(CFG_ORIGIN_RE, o_re);
		write_reg(CFG_ORIGIN_IM, o_im);
		write_reg(CFG_STEP_RE, s_re);
		write_reg(CFG_STEP_IM, s_im);
	endtask

	task automatic test_reset_defaults();
		send_pixel(12'd512, 12'd384);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		settle();
	endtask

	task automatic test_field_extremes();
		set_window(-2 * Q_ONE, -402653184, 196608, 196608);
		write_limit(200);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'hAAA, 12'h555);
		settle();
	endtask

	// With c at the origin the orbit never escapes, so the count equals the limit.
	task automatic test_iteration_counts();
		int unsigned counts [12] = '{0, 1, 9, 10, 11, 19, 20, 21, 99, 100, 101, 65535};
		set_window(0, 0, 0, 0);
		foreach (counts[k]) begin
			write_limit(counts[k]);
			send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
			settle();
		end
		write_reg(CFG_ORIGIN_RE, Q_ONE);
		send_pixel(12'd0, 12'd0);
		settle();
	endtask

	task automatic test_coordinate_saturation();
		write_limit(50);
		set_window(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);
		settle();
		set_window(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_pixel(12'd4095, 12'd4095);
		settle();
	endtask

	task automatic test_unmapped_registers();
		for (int k = CFG_MAX_ITER + 1; k < (1 << CFG_IDX_W); k++) begin
			write_reg(k[CFG_IDX_W-1:0], $urandom());
		end
		send_pixel(12'd2730, 12'd2048);
		settle();
	endtask

	task automatic test_output_backpressure();
		tx_gaps_on = 1'b0;
		set_window(-2 * Q_ONE, -402653184, 196608, 196608);
		write_limit(20);
		rx_hold_cycles = 400;
		repeat (12) send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
		settle();
		tx_gaps_on = 1'b1;
		repeat (3) send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
		settle();
		repeat (3) send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
		settle();
	endtask

	task automatic pick_zoom_window(bit deep);
		int center_re, center_im, step_re, step_im, span;
		span = $urandom_range(8, 18);
		step_re = (1 << span) + $urandom_range(0, (1 << span) - 1);
		step_im = (1 << span) + $urandom_range(0, (1 << span) - 1);
		if ($urandom_range(0, 1)) step_re = -step_re;
		if ($urandom_range(0, 1)) step_im = -step_im;
		center_re = $urandom_range(0, 671088640) - 536870912;
		center_im = $urandom_range(0, 671088640) - 335544320;
		set_window(center_re - 2048 * step_re, center_im - 2048 * step_im, step_re, step_im);
		write_limit(deep ? $urandom_range(64, 250) : $urandom_range(0, 64));
	endtask

	task automatic pick_wild_window();
		set_window($urandom(), $urandom(), $urandom(), $urandom());
		write_reg(CFG_IDX_W'(CFG_MAX_ITER
			+ $urandom_range(1, (1 << CFG_IDX_W) - 1 - CFG_MAX_ITER)), $urandom());
		write_limit($urandom_range(0, 300));
	endtask

	task automatic test_random_windows();
		for (int phase = 0; phase < 12; phase++) begin
			tx_gaps_on = $urandom_range(0, 3) != 0;
			rx_gaps_on = $urandom_range(0, 3) != 0;
			if (phase % 4 == 3) begin
				pick_wild_window();
			end else begin
				pick_zoom_window(phase % 4 == 1);
			end
			repeat (50) send_pixel(PIX_W'($urandom_range(0, 4095)),
				PIX_W'($urandom_range(0, 4095)));
			settle();
		end
	endtask

	initial begin : run_regression
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_field_extremes();
		test_iteration_counts();
		test_coordinate_saturation();
		test_unmapped_registers();
		test_output_backpressure();
		test_random_windows();
		settle();
		repeat (64) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
